@@ rtl/flood_relay_slot_controller_macros.svh @@
// Assertion helpers for the flood relay slot controller.
// FRSC_ASSERT_SAME: antecedent implies consequent in the same cycle.
// FRSC_ASSERT_NEXT: antecedent implies consequent in the next cycle.
`ifndef FLOOD_RELAY_SLOT_CONTROLLER_MACROS_SVH
`define FLOOD_RELAY_SLOT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

`define FRSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frsc: same-cycle check failed");

`define FRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frsc: next-cycle check failed");

`else

`define FRSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define FRSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/frsc_pkg.sv @@
package frsc_pkg;

    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_RX   = 2'd1,
        ST_TX   = 2'd2,
        ST_OFF  = 2'd3
    } radio_state_t;

    localparam logic CMD_ROUND_BEGIN = 1'b0;
    localparam logic CMD_SLOT        = 1'b1;

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_INITIATOR         = 2'd0;
    localparam logic [1:0] REG_MAX_TRANSMISSIONS = 2'd1;
    localparam logic [1:0] REG_RESTART_INTERVAL  = 2'd2;
    localparam logic [1:0] REG_ROUND_SLOTS       = 2'd3;

    localparam logic        RST_INITIATOR         = 1'b0;
    localparam logic [3:0]  RST_MAX_TRANSMISSIONS = 4'd3;
    localparam logic [4:0]  RST_RESTART_INTERVAL  = 5'd5;
    localparam logic [15:0] RST_ROUND_SLOTS       = 16'd255;

    localparam logic [4:0] TX_CNT_MAX = 5'd31;

    // bytes of the received word that replace the held value
    localparam int VALUE_BYTES = 4;
    localparam int LATCH_BYTES = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;
    localparam logic [31:0] LATCH_MASK = (LATCH_BYTES >= 4) ? 32'hFFFF_FFFF :
                                         ((32'd1 << (LATCH_BYTES * 8)) - 32'd1);

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        logic        initiator;
        logic [3:0]  max_transmissions;
        logic [4:0]  restart_interval;
        logic [15:0] round_slots;
    } cfg_t;

    typedef struct packed {
        logic         cmd;
        logic [15:0]  slot_index;
        radio_state_t radio_state;
        logic         rx_ok;
        logic [31:0]  rx_value;
        logic [31:0]  start_value;
    } item_t;

    typedef struct packed {
        radio_state_t next_radio;
        logic [15:0]  halt_slot_out;
        logic [16:0]  done_slot;
        logic [31:0]  flood_value;
    } result_t;

endpackage

@@ rtl/flood_relay_slot_controller.sv @@
// Flood relay slot controller: one radio decision per slot of a flooding round.
// Input stream (s_axis_*): tuser carries the command (round begin or slot
// outcome), tdata the slot index, radio state, success flag, received word and
// the initiator's start value. Each accepted item yields exactly one result
// item on the output stream (m_axis_*): next radio state, off slot, completion
// slot and the held flood value.
// An accepted item sits in the input register, the decision logic then loads
// the result register, and the receiver takes the result from there.
// Throughput: one item per cycle while m_axis_tready stays high; the decision
// logic is a single pass.
// When the receiver holds m_axis_tready low, the result register keeps its item
// and the input register keeps one more; s_axis_tready drops only when both
// are full and the result is not taken.
// Configuration through the APB port (registers at 0x0, 0x4, 0x8, 0xC); write
// it only while no item is in flight. pready is always high.
// Reset empties both pipeline stages and clears the round state; the off slot
// resets to the round length default and the registers to their defaults.
`include "flood_relay_slot_controller_macros.svh"

module flood_relay_slot_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] slot_index, [17:16] radio_state, [18] rx_ok, [50:19] rx_value,
    // [82:51] start_value, [87:83] zero
    input  logic [frsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  logic                          s_axis_tuser,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] next_radio, [17:2] halt_slot_out, [34:18] done_slot,
    // [66:35] flood_value, [71:67] zero
    output logic [frsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    frsc_pkg::cfg_t    cfg;
    frsc_pkg::item_t   item_reg;
    frsc_pkg::result_t result;
    frsc_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    assign pready = 1'b1;

    frsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.cmd         <= s_axis_tuser;
            item_reg.slot_index  <= s_axis_tdata[15:0];
            item_reg.radio_state <= frsc_pkg::radio_state_t'(s_axis_tdata[17:16]);
            item_reg.rx_ok       <= s_axis_tdata[18];
            item_reg.rx_value    <= s_axis_tdata[50:19];
            item_reg.start_value <= s_axis_tdata[82:51];
        end
    end

    frsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .commit (advance),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, result_reg.flood_value, result_reg.done_slot,
                            result_reg.halt_slot_out, result_reg.next_radio};

    `FRSC_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, advance, m_axis_tvalid)
    `FRSC_ASSERT_SAME(a_empty_stage_ready, clk, rst_n, !in_valid_reg, s_axis_tready)
    `FRSC_ASSERT_SAME(a_round_begin_no_done, clk, rst_n,
        m_axis_tvalid && (m_axis_tdata[1:0] == frsc_pkg::ST_INIT),
        m_axis_tdata[34:18] == 17'd0)
    `FRSC_ASSERT_NEXT(a_stall_keeps_input, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg)

endmodule

@@ rtl/frsc_cfg.sv @@
module frsc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [frsc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output frsc_pkg::cfg_t             cfg
);

    frsc_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initiator         <= frsc_pkg::RST_INITIATOR;
            cfg_reg.max_transmissions <= frsc_pkg::RST_MAX_TRANSMISSIONS;
            cfg_reg.restart_interval  <= frsc_pkg::RST_RESTART_INTERVAL;
            cfg_reg.round_slots       <= frsc_pkg::RST_ROUND_SLOTS;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                frsc_pkg::REG_INITIATOR:         cfg_reg.initiator         <= pwdata[0];
                frsc_pkg::REG_MAX_TRANSMISSIONS: cfg_reg.max_transmissions <= pwdata[3:0];
                frsc_pkg::REG_RESTART_INTERVAL:  cfg_reg.restart_interval  <= pwdata[4:0];
                frsc_pkg::REG_ROUND_SLOTS:       cfg_reg.round_slots       <= pwdata[15:0];
                default:                         cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            frsc_pkg::REG_INITIATOR:         prdata = {31'd0, cfg_reg.initiator};
            frsc_pkg::REG_MAX_TRANSMISSIONS: prdata = {28'd0, cfg_reg.max_transmissions};
            frsc_pkg::REG_RESTART_INTERVAL:  prdata = {27'd0, cfg_reg.restart_interval};
            frsc_pkg::REG_ROUND_SLOTS:       prdata = {16'd0, cfg_reg.round_slots};
            default:                         prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/frsc_core.sv @@
module frsc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  frsc_pkg::cfg_t    cfg,
    input  frsc_pkg::item_t   item,
    input  logic              commit,
    output frsc_pkg::result_t result
);

    logic [4:0]  xmit_cnt_reg,   xmit_cnt_next;
    logic [4:0]  idle_phase_reg, idle_phase_next;
    logic        got_rx_reg,     got_rx_next;
    logic [31:0] held_reg,       held_next;
    logic [15:0] halt_slot_reg,  halt_slot_next;
    logic [16:0] done_slot_reg,  done_slot_next;

    frsc_pkg::radio_state_t decision;
    logic [4:0] interval;
    logic [5:0] idle_inc;
    logic [4:0] tx_inc;
    logic       rx_good;

    assign interval = (cfg.restart_interval == 5'd0) ? 5'd1 : cfg.restart_interval;
    assign idle_inc = {1'b0, idle_phase_reg} + 6'd1;
    assign tx_inc   = (xmit_cnt_reg < frsc_pkg::TX_CNT_MAX) ? (xmit_cnt_reg + 5'd1)
                                                            : xmit_cnt_reg;
    assign rx_good  = (item.radio_state == frsc_pkg::ST_RX) && item.rx_ok;

    always_comb
    begin
        decision        = frsc_pkg::ST_INIT;
        xmit_cnt_next   = xmit_cnt_reg;
        idle_phase_next = idle_phase_reg;
        got_rx_next     = got_rx_reg;
        held_next       = held_reg;
        halt_slot_next  = halt_slot_reg;
        done_slot_next  = done_slot_reg;

        if (item.cmd == frsc_pkg::CMD_ROUND_BEGIN)
        begin
            got_rx_next     = 1'b0;
            xmit_cnt_next   = 5'd0;
            idle_phase_next = 5'd0;
            held_next       = cfg.initiator ? item.start_value : 32'd0;
            halt_slot_next  = cfg.round_slots;
            done_slot_next  = 17'd0;
        end
        else
        begin
            // first good reception latches the word and the completion slot
            if (rx_good && !got_rx_reg)
            begin
                held_next      = (held_reg & ~frsc_pkg::LATCH_MASK) |
                                 (item.rx_value & frsc_pkg::LATCH_MASK);
                done_slot_next = {1'b0, item.slot_index} + 17'd1;
                got_rx_next    = 1'b1;
            end

            decision = frsc_pkg::ST_RX;
            unique case (item.radio_state)
                frsc_pkg::ST_INIT:
                begin
                    decision = cfg.initiator ? frsc_pkg::ST_TX : frsc_pkg::ST_RX;
                end
                frsc_pkg::ST_RX:
                begin
                    if (item.rx_ok)
                    begin
                        decision        = frsc_pkg::ST_TX;
                        idle_phase_next = 5'd0;
                    end
                    else
                    begin
                        // idle slot: phase wraps at the interval; initiator or informed node restarts on wrap
                        idle_phase_next = (idle_inc >= {1'b0, interval}) ? 5'd0
                                                                         : idle_inc[4:0];
                        if ((cfg.initiator || got_rx_reg) && idle_phase_next == 5'd0)
                        begin
                            decision = frsc_pkg::ST_TX;
                        end
                    end
                end
                frsc_pkg::ST_TX:
                begin
                    xmit_cnt_next = tx_inc;
                    decision      = (tx_inc > {1'b0, cfg.max_transmissions}) ? frsc_pkg::ST_OFF
                                                                             : frsc_pkg::ST_RX;
                end
                default:
                begin
                    decision = frsc_pkg::ST_RX;
                end
            endcase

            if (decision == frsc_pkg::ST_OFF)
            begin
                halt_slot_next = item.slot_index;
            end
        end
    end

    assign result.next_radio    = decision;
    assign result.halt_slot_out = halt_slot_next;
    assign result.done_slot     = done_slot_next;
    assign result.flood_value   = held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xmit_cnt_reg   <= 5'd0;
            idle_phase_reg <= 5'd0;
            got_rx_reg     <= 1'b0;
            held_reg       <= 32'd0;
            halt_slot_reg  <= frsc_pkg::RST_ROUND_SLOTS;
            done_slot_reg  <= 17'd0;
        end
        else if (commit)
        begin
            xmit_cnt_reg   <= xmit_cnt_next;
            idle_phase_reg <= idle_phase_next;
            got_rx_reg     <= got_rx_next;
            held_reg       <= held_next;
            halt_slot_reg  <= halt_slot_next;
            done_slot_reg  <= done_slot_next;
        end
    end

endmodule
